/* rtl/core/ncps_pkg.sv */
// Package for the nearest colour pixel search core.
// Holds the beat payload types, register indexes and search constants.
// Used by the interfaces and every module of the core.
package ncps_pkg;

	localparam int unsigned ChanW  = 8;
	localparam int unsigned CoordW = 16;
	localparam int unsigned DistW  = 9;

	// Best distance before any candidate has been seen: beyond every real distance.
	localparam logic [DistW-1:0] DIST_NONE = 9'd256;
	// A row end only stops the scan if the best distance is within this limit.
	localparam logic [DistW-1:0] EARLY_STOP_LIMIT = 9'd8;

	typedef enum logic [1:0] {
		CFG_TARGET_RED   = 2'd0,
		CFG_TARGET_GREEN = 2'd1,
		CFG_TARGET_BLUE  = 2'd2,
		CFG_TOLERANCE    = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic signed [CoordW-1:0] pixel_x;
		logic signed [CoordW-1:0] pixel_y;
		logic [ChanW-1:0]         pixel_red;
		logic [ChanW-1:0]         pixel_green;
		logic [ChanW-1:0]         pixel_blue;
		logic                     end_of_row;
		logic                     end_of_scan;
	} pixel_t;

	typedef struct packed {
		logic                     found;
		logic signed [CoordW-1:0] hit_x;
		logic signed [CoordW-1:0] hit_y;
		logic [ChanW-1:0]         hit_red;
		logic [ChanW-1:0]         hit_green;
		logic [ChanW-1:0]         hit_blue;
		logic [ChanW-1:0]         hit_distance;
	} hit_t;

	typedef struct packed {
		logic [ChanW-1:0] red;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] blue;
	} colour_t;

endpackage

/* rtl/core/ncps_pixel_if.sv */
// Valid/ready channel carrying one sampled pixel per beat.
// Depends on ncps_pkg for the pixel payload type.
interface ncps_pixel_if import ncps_pkg::*; ();
	logic   valid;
	logic   ready;
	pixel_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/ncps_hit_if.sv */
// Valid/ready channel carrying one search result per beat.
// Depends on ncps_pkg for the result payload type.
interface ncps_hit_if import ncps_pkg::*; ();
	logic valid;
	logic ready;
	hit_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/ncps_dist.sv */
// Chebyshev colour distance: largest per-channel absolute difference.
// Purely combinational; depends on ncps_pkg.
module ncps_dist import ncps_pkg::*; (
	input  colour_t          pixel,
	input  colour_t          target,
	output logic [ChanW-1:0] chan_dist
);
	logic [ChanW-1:0] d_red;
	logic [ChanW-1:0] d_green;
	logic [ChanW-1:0] d_blue;
	logic [ChanW-1:0] d_rg;

	assign d_red   = (pixel.red > target.red) ? pixel.red - target.red : target.red - pixel.red;
	assign d_green = (pixel.green > target.green) ? pixel.green - target.green
		: target.green - pixel.green;
	assign d_blue  = (pixel.blue > target.blue) ? pixel.blue - target.blue
		: target.blue - pixel.blue;

	assign d_rg      = (d_green > d_red) ? d_green : d_red;
	assign chan_dist = (d_blue > d_rg) ? d_blue : d_rg;
endmodule

/* rtl/core/ncps_track.sv */
// Best-candidate tracker: keeps the closest pixel of the current scan,
// the stop flag, and forms the result on an end-of-scan beat. Depends on ncps_pkg.
module ncps_track import ncps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  pixel_t           pixel,
	input  logic [ChanW-1:0] chan_dist,
	input  logic [ChanW-1:0] tolerance,
	output hit_t             result
);
	logic [DistW-1:0] best_dist_q;
	pixel_t           best_q;
	logic             have_q;
	logic             stopped_q;

	logic             upd;
	logic [DistW-1:0] dist_ext;
	logic [DistW-1:0] tol_ext;
	logic [DistW-1:0] nxt_dist;
	pixel_t           nxt_best;
	logic             nxt_have;
	logic             nxt_stop;
	logic             found;

	assign dist_ext = {1'b0, chan_dist};
	assign tol_ext  = {1'b0, tolerance};

	// Strict less-than keeps the earliest pixel on a tie.
	assign upd      = !stopped_q && (dist_ext < best_dist_q);
	assign nxt_dist = upd ? dist_ext : best_dist_q;
	assign nxt_best = upd ? pixel : best_q;
	assign nxt_have = have_q | upd;
	assign nxt_stop = stopped_q | (upd && chan_dist == '0)
		| (pixel.end_of_row && nxt_have && nxt_dist <= tol_ext
			&& nxt_dist <= EARLY_STOP_LIMIT);
	assign found    = nxt_have && (nxt_dist <= tol_ext);

	always_comb begin
		result = '0;
		if (found) begin
			result.found        = 1'b1;
			result.hit_x        = nxt_best.pixel_x;
			result.hit_y        = nxt_best.pixel_y;
			result.hit_red      = nxt_best.pixel_red;
			result.hit_green    = nxt_best.pixel_green;
			result.hit_blue     = nxt_best.pixel_blue;
			result.hit_distance = nxt_dist[ChanW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_dist_q <= DIST_NONE;
			best_q      <= '0;
			have_q      <= 1'b0;
			stopped_q   <= 1'b0;
		end else if (step) begin
			if (pixel.end_of_scan) begin
				best_dist_q <= DIST_NONE;
				best_q      <= '0;
				have_q      <= 1'b0;
				stopped_q   <= 1'b0;
			end else begin
				best_dist_q <= nxt_dist;
				best_q      <= nxt_best;
				have_q      <= nxt_have;
				stopped_q   <= nxt_stop;
			end
		end
	end
endmodule

/* rtl/core/nearest_color_pixel_search_core.sv */
// Nearest colour pixel search core: closest pixel to a target colour, Chebyshev metric.
// An end-of-scan pixel is held in the input register and its result in the output one.
// Throughput: one pixel per cycle, set by the distance and tracker update, unless
// an end-of-scan pixel must wait while a result waits in the output register.
// Reset clears the targets, tolerance, tracker state and both valid flags.
// Depends on ncps_pkg, ncps_pixel_if, ncps_hit_if, ncps_dist and ncps_track.
module nearest_color_pixel_search_core import ncps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	ncps_pixel_if.sink         pixel,
	ncps_hit_if.source         hit,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [ChanW-1:0]   cfg_data
);
	colour_t          target_q;
	logic [ChanW-1:0] tolerance_q;

	logic             valid_s1;
	pixel_t           pixel_s1;
	logic             hit_valid_q;
	hit_t             hit_q;

	logic             advance;
	logic             step;
	logic [ChanW-1:0] chan_dist;
	colour_t          pixel_colour;
	hit_t             result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= '0;
			tolerance_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_TARGET_RED:   target_q.red   <= cfg_data;
				CFG_TARGET_GREEN: target_q.green <= cfg_data;
				CFG_TARGET_BLUE:  target_q.blue  <= cfg_data;
				CFG_TOLERANCE:    tolerance_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// A beat without an end-of-scan mark never needs the output register.
	assign advance     = !pixel_s1.end_of_scan || !hit_valid_q || hit.ready;
	assign step        = valid_s1 && advance;
	assign pixel.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel.valid && pixel.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel.valid && pixel.ready) begin
			pixel_s1 <= pixel.data;
		end
	end

	assign pixel_colour = '{red: pixel_s1.pixel_red, green: pixel_s1.pixel_green,
		blue: pixel_s1.pixel_blue};

	ncps_dist u_dist (
		.pixel     (pixel_colour),
		.target    (target_q),
		.chan_dist (chan_dist)
	);

	ncps_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.pixel     (pixel_s1),
		.chan_dist (chan_dist),
		.tolerance (tolerance_q),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_valid_q <= 1'b0;
		end else if (step && pixel_s1.end_of_scan) begin
			hit_valid_q <= 1'b1;
		end else if (hit.ready) begin
			hit_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && pixel_s1.end_of_scan) begin
			hit_q <= result;
		end
	end

	assign hit.valid = hit_valid_q;
	assign hit.data  = hit_q;
endmodule

/* tb/ncps_search_checker.sv */
// Checker for the nearest colour pixel search core: predicts each result beat and compares it.
// Depends on ncps_pkg for the pixel and result payload types and the register indexes.
`timescale 1ns / 1ps

module ncps_search_checker import ncps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pix_valid,
	input  logic             pix_ready,
	input  pixel_t           pix_data,
	input  logic             hit_valid,
	input  logic             hit_ready,
	input  hit_t             hit_data,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [ChanW-1:0] cfg_data,
	output int               mismatches,
	output int               waiting
);

	colour_t          target;
	logic [ChanW-1:0] tolerance;

	logic [DistW-1:0] best_dist;
	pixel_t           best_px;
	logic             have_candidate;
	logic             stopped;

	hit_t expected_hits[$];

	initial mismatches = 0;

	function automatic int chan_diff(input logic [ChanW-1:0] a, input logic [ChanW-1:0] b);
		return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
	endfunction

	task automatic forget_best();
		best_dist      = DIST_NONE;
		best_px        = '0;
		have_candidate = 1'b0;
		stopped        = 1'b0;
	endtask

	// Update the search state with one accepted pixel; an end-of-scan pixel queues a result.
	task automatic track_pixel(input pixel_t p);
		int   d;
		int   dg;
		int   db;
		hit_t res;
		if (!stopped) begin
			d  = chan_diff(p.pixel_red, target.red);
			dg = chan_diff(p.pixel_green, target.green);
			db = chan_diff(p.pixel_blue, target.blue);
			if (dg > d) d = dg;
			if (db > d) d = db;
			if (d < best_dist) begin
				best_dist      = d[DistW-1:0];
				best_px        = p;
				have_candidate = 1'b1;
				if (d == 0) stopped = 1'b1;
			end
			if (!stopped && p.end_of_row && have_candidate && best_dist <= tolerance &&
					best_dist <= EARLY_STOP_LIMIT)
				stopped = 1'b1;
		end
		if (p.end_of_scan) begin
			res = '0;
			if (have_candidate && best_dist <= tolerance) begin
				res.found        = 1'b1;
				res.hit_x        = best_px.pixel_x;
				res.hit_y        = best_px.pixel_y;
				res.hit_red      = best_px.pixel_red;
				res.hit_green    = best_px.pixel_green;
				res.hit_blue     = best_px.pixel_blue;
				res.hit_distance = best_dist[ChanW-1:0];
			end
			expected_hits = {expected_hits, res};
			forget_best();
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		hit_t want;
		if (!arst_n) begin
			target    = '0;
			tolerance = '0;
			forget_best();
			expected_hits.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
					CFG_TARGET_RED:   target.red   = cfg_data;
					CFG_TARGET_GREEN: target.green = cfg_data;
					CFG_TARGET_BLUE:  target.blue  = cfg_data;
					CFG_TOLERANCE:    tolerance    = cfg_data;
					default: ;
				endcase
			end
			// Results leave before the pixel of this edge is tracked, so the queue stays in order.
			if (hit_valid && hit_ready) begin
				if (expected_hits.size() == 0) begin
					$error("result beat arrived with no result expected");
					mismatches++;
				end else begin
					want = expected_hits.pop_front();
					check_field("found", int'(want.found), int'(hit_data.found));
					check_field("hit_x", int'(want.hit_x), int'(hit_data.hit_x));
					check_field("hit_y", int'(want.hit_y), int'(hit_data.hit_y));
					check_field("hit_red", int'(want.hit_red), int'(hit_data.hit_red));
					check_field("hit_green", int'(want.hit_green), int'(hit_data.hit_green));
					check_field("hit_blue", int'(want.hit_blue), int'(hit_data.hit_blue));
					check_field("hit_distance", int'(want.hit_distance),
						int'(hit_data.hit_distance));
				end
			end
			if (pix_valid && pix_ready) track_pixel(pix_data);
		end
		waiting = expected_hits.size();
	end

endmodule

/* tb/nearest_color_pixel_search_core_tb.sv */
// Testbench top for the nearest colour pixel search core: clock, reset, pixel scans and
// register writes. Depends on ncps_pkg, both channel interfaces and ncps_search_checker.
`timescale 1ns / 1ps

module nearest_color_pixel_search_core_tb;
	import ncps_pkg::*;

	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_ITEMS  = 500;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [ChanW-1:0] cfg_data;

	int mismatches;
	int waiting;
	int items_sent;
	bit tx_idle;
	bit rx_idle;
	bit long_hold;

	colour_t          cur_target;
	logic [ChanW-1:0] cur_tol;

	ncps_pixel_if pixel ();
	ncps_hit_if   hit ();

	nearest_color_pixel_search_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pixel),
		.hit       (hit),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ncps_search_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pixel.valid),
		.pix_ready  (pixel.ready),
		.pix_data   (pixel.data),
		.hit_valid  (hit.valid),
		.hit_ready  (hit.ready),
		.hit_data   (hit.data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.waiting    (waiting)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Result side: random stall bursts, plus one long hold so that the core backs up.
	initial begin
		hit.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				hit.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
				hit.ready <= 1'b1;
			end else if (rx_idle && $urandom_range(0, 6) == 0) begin
				hit.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				hit.ready <= 1'b1;
			end else begin
				hit.ready <= 1'b1;
			end
		end
	end

	function automatic pixel_t px(input int x, input int y, input int r, input int g,
			input int b, input bit eor, input bit eos);
		pixel_t p;
		p.pixel_x     = x[CoordW-1:0];
		p.pixel_y     = y[CoordW-1:0];
		p.pixel_red   = r[ChanW-1:0];
		p.pixel_green = g[ChanW-1:0];
		p.pixel_blue  = b[ChanW-1:0];
		p.end_of_row  = eor;
		p.end_of_scan = eos;
		return p;
	endfunction

	function automatic int near_channel(input logic [ChanW-1:0] t, input int spread);
		int v;
		v = int'(t) + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return v;
	endfunction

	// Called at a rising edge; returns at the edge where the beat is taken, valid still high.
	task automatic send_pixel(input pixel_t p);
		if (tx_idle && $urandom_range(0, 4) == 0) begin
			pixel.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		pixel.valid <= 1'b1;
		pixel.data  <= p;
		do @(posedge clk); while (!pixel.ready);
		items_sent++;
	endtask

	// Lets every expected result come back and the core go quiet before registers change.
	task automatic settle();
		pixel.valid <= 1'b0;
		@(posedge clk);
		wait (waiting == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [ChanW-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input int r, input int g, input int b, input int tol);
		cur_target.red   = r[ChanW-1:0];
		cur_target.green = g[ChanW-1:0];
		cur_target.blue  = b[ChanW-1:0];
		cur_tol          = tol[ChanW-1:0];
		write_reg(CFG_TARGET_RED, cur_target.red);
		write_reg(CFG_TARGET_GREEN, cur_target.green);
		write_reg(CFG_TARGET_BLUE, cur_target.blue);
		write_reg(CFG_TOLERANCE, cur_tol);
	endtask

	// One raster scan of random shape; a few are broken, with marks in random places.
	task automatic random_scan();
		int rows;
		int cols;
		int x0;
		int y0;
		int stride;
		int kind;
		int spread;
		int r;
		int c;
		bit broken;
		pixel_t p;
		rows   = $urandom_range(1, 4);
		cols   = $urandom_range(1, 6);
		x0     = $urandom;
		y0     = $urandom;
		stride = $urandom_range(1, 8);
		broken = ($urandom_range(0, 9) == 0);
		for (r = 0; r < rows; r++) begin
			for (c = 0; c < cols; c++) begin
				kind   = $urandom_range(0, 9);
				spread = $urandom_range(1, 12);
				if (kind == 0)
					p = px(x0 + c * stride, y0 + r, int'(cur_target.red),
						int'(cur_target.green), int'(cur_target.blue), 1'b0, 1'b0);
				else if (kind <= 5)
					p = px(x0 + c * stride, y0 + r, near_channel(cur_target.red, spread),
						near_channel(cur_target.green, spread),
						near_channel(cur_target.blue, spread), 1'b0, 1'b0);
				else
					p = px($urandom, $urandom, $urandom, $urandom, $urandom, 1'b0, 1'b0);
				if (broken) begin
					p.end_of_row  = 1'($urandom_range(0, 1));
					p.end_of_scan = ($urandom_range(0, 5) == 0);
				end else begin
					p.end_of_row  = (c == cols - 1);
					p.end_of_scan = (r == rows - 1) && (c == cols - 1);
				end
				send_pixel(p);
			end
		end
	endtask

	initial begin
		int ph;
		int phase_end;
		int random_start;
		int i;
		arst_n      = 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= CFG_TARGET_RED;
		cfg_data    <= '0;
		pixel.valid <= 1'b0;
		pixel.data  <= '0;
		items_sent  = 0;
		tx_idle     = 1'b1;
		rx_idle     = 1'b1;
		long_hold   = 1'b0;
		cur_target  = '0;
		cur_tol     = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: black target, no tolerance.
		send_pixel(px(100, -100, 1, 0, 0, 1'b0, 1'b1));
		send_pixel(px(0, 0, 0, 0, 0, 1'b0, 1'b1));
		settle();

		set_config(100, 150, 200, 10);
		// Row end inside tolerance and the early-stop limit stops the scan; later pixels ignored.
		send_pixel(px(-32768, 32767, 255, 0, 128, 1'b0, 1'b0));
		send_pixel(px(32767, -32768, 105, 150, 200, 1'b1, 1'b0));
		send_pixel(px(1, 1, 100, 150, 200, 1'b1, 1'b0));
		send_pixel(px(2, 1, 255, 255, 255, 1'b0, 1'b1));
		// Distance 9 is within tolerance but beyond the early-stop limit; then an exact match.
		send_pixel(px(5, 5, 91, 150, 200, 1'b1, 1'b0));
		send_pixel(px(6, 5, 100, 150, 200, 1'b0, 1'b0));
		send_pixel(px(7, 5, 0, 0, 0, 1'b1, 1'b1));
		// Equal distances: the earlier pixel must be kept.
		send_pixel(px(0, 0, 110, 150, 200, 1'b0, 1'b0));
		send_pixel(px(1, 0, 100, 140, 200, 1'b0, 1'b0));
		send_pixel(px(2, 0, 255, 255, 255, 1'b1, 1'b1));
		// Best candidate outside tolerance gives an empty result.
		send_pixel(px(0, 0, 0, 0, 0, 1'b0, 1'b0));
		send_pixel(px(1, 0, 0, 255, 0, 1'b0, 1'b1));
		// End of scan with no row end.
		send_pixel(px(-1, -1, 95, 155, 195, 1'b0, 1'b1));
		// A scan left open across a tolerance change picks up the new setting.
		send_pixel(px(3, 3, 111, 150, 200, 1'b0, 1'b0));
		settle();
		set_config(100, 150, 200, 255);
		send_pixel(px(4, 4, 0, 0, 0, 1'b0, 1'b1));
		settle();

		// Hold the result side off while single-pixel scans keep coming.
		tx_idle   = 1'b0;
		long_hold = 1'b1;
		for (i = 0; i < 30; i++)
			send_pixel(px($urandom, $urandom, $urandom, $urandom, $urandom, 1'b0, 1'b1));
		settle();

		random_start = items_sent;
		for (ph = 0; items_sent < random_start + RANDOM_ITEMS; ph++) begin
			if (ph == 0)
				set_config(0, 0, 0, 0);
			else if (ph == 1)
				set_config(255, 255, 255, 255);
			else if (ph % 3 == 0)
				set_config($urandom, $urandom, $urandom, $urandom_range(0, 255));
			else
				set_config($urandom, $urandom, $urandom, $urandom_range(0, 16));
			if (items_sent >= random_start + RANDOM_ITEMS - 100) begin
				tx_idle = 1'b0;
				rx_idle = 1'b0;
			end else begin
				tx_idle = ($urandom_range(0, 3) != 0);
				rx_idle = ($urandom_range(0, 3) != 0);
			end
			phase_end = items_sent + 60;
			while (items_sent < phase_end)
				random_scan();
			settle();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && waiting == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
